// ===== rtl/sparse_scatter_max_reduce_unit_assert.svh =====
// assertion macros for the scatter max unit
`ifndef SPARSE_SCATTER_MAX_REDUCE_UNIT_ASSERT_SVH
`define SPARSE_SCATTER_MAX_REDUCE_UNIT_ASSERT_SVH

// antecedent implies consequent on the next edge
`define SSMR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// property holds at every edge
`define SSMR_ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`endif

// ===== rtl/ssmr_pkg.sv =====
// ----------------------------------------------------------------------------
// ssmr_pkg
// shared constants and helpers for the scatter max unit
// ----------------------------------------------------------------------------
package ssmr_pkg;
   localparam int DEF_MAX_RANK  = 4;
   localparam int DEF_OUT_DEPTH = 4096;
   localparam int AXES          = 4;
   localparam logic [31:0] NEG_INF_BITS = 32'hFF800000;
   localparam logic [31:0] QNAN_BITS    = 32'h7FC00000;

   localparam logic [2:0] CSR_RANK    = 3'd0;
   localparam logic [2:0] CSR_RED     = 3'd1;
   localparam logic [2:0] CSR_DIM0    = 3'd2;
   localparam logic [2:0] CSR_DIM1    = 3'd3;
   localparam logic [2:0] CSR_DIM2    = 3'd4;
   localparam logic [2:0] CSR_DIM3    = 3'd5;

   localparam logic REQ_ACC  = 1'b0;
   localparam logic REQ_READ = 1'b1;

   function automatic logic is_nan(input logic [31:0] b);
      is_nan = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
   endfunction

   function automatic logic [31:0] order_key(input logic [31:0] b);
      order_key = b[31] ? ~b : (b | 32'h80000000);
   endfunction

   function automatic logic [31:0] fmax_bits(input logic [31:0] a, input logic [31:0] b);
      logic na, nb;
      na = is_nan(a);
      nb = is_nan(b);
      if (na && nb) fmax_bits = QNAN_BITS;
      else if (na) fmax_bits = b;
      else if (nb) fmax_bits = a;
      else fmax_bits = (order_key(a) >= order_key(b)) ? a : b;
   endfunction
endpackage

// ===== rtl/ssmr_ram.sv =====
// ----------------------------------------------------------------------------
// ssmr_ram
// single port write, single port read ram with registered read
// ----------------------------------------------------------------------------
module ssmr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== rtl/sparse_scatter_max_reduce_unit.sv =====
// ----------------------------------------------------------------------------
// sparse_scatter_max_reduce_unit
// scatter of sparse entries into a float32 max store, with cell reads
// ----------------------------------------------------------------------------
// After reset a clearing pass writes negative infinity to every cell, one per
// cycle, during which no request is taken (csr writes are).
// An accumulate request then runs through a sequencer: one step per axis in
// use forms the linear index, with one 32x16 multiply per kept axis after the
// first, then a store read, the max and write back, and the response beat.
// A read request skips the index steps and the write back; an index out of
// range goes straight to the response. A new request is taken only once the
// response to the last one has been accepted.
module sparse_scatter_max_reduce_unit
   import ssmr_pkg::*;
#(
   parameter int MAX_RANK  = DEF_MAX_RANK,
   parameter int OUT_DEPTH = DEF_OUT_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // req_type
   input  logic         req_tuser,
   // coord_0, coord_1, coord_2, coord_3, entry_value, read_index, pad
   input  logic [135:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // index_error
   output logic         rsp_tuser,
   // cell_index, cell_value, pad
   output logic [47:0]  rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [15:0]  csr_data
);
   localparam int AW = $clog2(OUT_DEPTH);
   localparam int URANK = (MAX_RANK < AXES) ? MAX_RANK : AXES;

   localparam logic [2:0] ST_CLR  = 3'd0;
   localparam logic [2:0] ST_IDLE = 3'd1;
   localparam logic [2:0] ST_IDX  = 3'd2;
   localparam logic [2:0] ST_RD   = 3'd3;
   localparam logic [2:0] ST_MAX  = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   logic [2:0]  st_ff, st_in;
   logic [AW:0] clr_ff, clr_in;
   logic [2:0]  rank_ff;
   logic [1:0]  red_ff;
   logic [15:0] dim_ff [AXES];
   logic [15:0] crd_ff [AXES];
   logic [31:0] val_ff;
   logic        rd_ff;
   logic [31:0] idx_ff, idx_in;
   logic        first_ff, first_in;
   logic [2:0]  ax_ff, ax_in;
   logic [2:0]  ur;
   logic        err_ff, err_in;
   logic [31:0] res_ff, res_in;
   logic        ram_we;
   logic [AW-1:0] ram_wa, ram_ra;
   logic [31:0] ram_wd, ram_rd;
   logic [47:0] mul;

   assign csr_ready  = 1'b1;
   assign req_tready = (st_ff == ST_IDLE);
   assign rsp_tvalid = (st_ff == ST_OUT);
   assign rsp_tuser  = err_ff;
   assign rsp_tdata  = {4'd0, err_ff ? 32'd0 : res_ff,
                        err_ff ? 12'd0 : 12'(idx_ff)};

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff <= 3'd4;
         red_ff  <= 2'd0;
         for (int i = 0; i < AXES; i++) dim_ff[i] <= 16'd1;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_RANK: rank_ff   <= csr_data[2:0];
            CSR_RED:  red_ff    <= csr_data[1:0];
            CSR_DIM0: dim_ff[0] <= csr_data;
            CSR_DIM1: dim_ff[1] <= csr_data;
            CSR_DIM2: dim_ff[2] <= csr_data;
            CSR_DIM3: dim_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         for (int i = 0; i < AXES; i++) crd_ff[i] <= req_tdata[16*i +: 16];
         val_ff <= req_tdata[95:64];
         rd_ff  <= req_tuser;
      end
   end

   assign ur  = (rank_ff > 3'(URANK)) ? 3'(URANK) : rank_ff;
   assign mul = idx_ff * dim_ff[ax_ff[1:0]];

   always_comb begin
      logic [48:0] s;
      st_in = st_ff; clr_in = clr_ff; idx_in = idx_ff; first_in = first_ff;
      ax_in = ax_ff; err_in = err_ff; res_in = res_ff;
      ram_we = 1'b0; ram_wa = clr_ff[AW-1:0]; ram_wd = NEG_INF_BITS;
      ram_ra = idx_ff[AW-1:0];
      s = 49'd0;
      case (st_ff)
         ST_CLR: begin
            ram_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (AW+1)'(OUT_DEPTH - 1)) st_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               idx_in = {20'd0, req_tdata[107:96]};
               first_in = 1'b1;
               ax_in = 3'd0;
               st_in = (req_tuser == REQ_READ) ? ST_RD : ST_IDX;
               if (req_tuser == REQ_ACC) idx_in = 32'd0;
            end
         end
         ST_IDX: begin
            if (ax_ff >= ur) begin
               st_in = ST_RD;
            end else begin
               if (ax_ff[1:0] != red_ff) begin
                  if (first_ff) s = {33'd0, crd_ff[ax_ff[1:0]]};
                  else s = {1'b0, mul} + {33'd0, crd_ff[ax_ff[1:0]]};
                  idx_in = (s > 49'hFFFFFFFF) ? 32'hFFFFFFFF : s[31:0];
                  first_in = 1'b0;
               end
               ax_in = ax_ff + 1'b1;
            end
         end
         ST_RD: begin
            err_in = (idx_ff >= 32'(OUT_DEPTH));
            st_in = err_in ? ST_OUT : ST_MAX;
         end
         ST_MAX: begin
            res_in = rd_ff ? ram_rd : fmax_bits(val_ff, ram_rd);
            ram_we = !rd_ff;
            ram_wa = idx_ff[AW-1:0];
            ram_wd = res_in;
            st_in = ST_OUT;
         end
         ST_OUT: if (rsp_tready) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= ST_CLR;
         clr_ff <= '0;
         err_ff <= 1'b0;
      end else begin
         st_ff <= st_in; clr_ff <= clr_in; err_ff <= err_in;
      end
      idx_ff <= idx_in; first_ff <= first_in; ax_ff <= ax_in; res_ff <= res_in;
   end

   ssmr_ram #(.WIDTH(32), .DEPTH(OUT_DEPTH)) u_store (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_wa), .wr_data(ram_wd),
      .rd_addr(ram_ra), .rd_data(ram_rd)
   );

`include "sparse_scatter_max_reduce_unit_assert.svh"
   `SSMR_ASSERT_NEXT(a_out_holds, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")
   `SSMR_ASSERT_ALWAYS(a_no_overlap, clock, reset, !(req_tready && rsp_tvalid),
      "request taken while result pending")
   `SSMR_ASSERT_ALWAYS(a_err_zero, clock, reset, !(rsp_tvalid && rsp_tuser) ||
      rsp_tdata == 48'd0, "error result carries data")
endmodule
